/* rtl/cdls_pkg.sv */
`timescale 1ns / 1ps
// Package of the clipped DDA line stepper: widths, register indexes, command
// and state types shared by the front end, the queue and the stepper.
// Depends on nothing.
package cdls_pkg;

    // Field widths of the channels.
    localparam int COORD_W    = 8;
    localparam int CELL_W     = 6;
    localparam int GLYPH_W    = 16;
    localparam int COLOR_W    = 24;
    localparam int DIM_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int ERR_W      = COORD_W + 1;

    // Largest screen dimension and depth of the command queue.
    localparam int MAX_SCREEN_DIM_DEF = 64;
    localparam int CMD_QUEUE_DEPTH    = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

    // Reset value of both screen registers.
    localparam logic [DIM_W-1:0] SCREEN_RESET = 7'd64;

    // A classified line command, ready for the stepper.
    typedef struct packed {
        logic                       xmaj;    // x is the major axis
        logic                       ma_dec;  // major coordinate counts down
        logic                       mi_neg;  // minor coordinate moves down
        logic signed [COORD_W-1:0]  sma;     // major coordinate of first cell
        logic signed [COORD_W-1:0]  smi;     // minor coordinate of first cell
        logic [COORD_W-1:0]         amaj;    // major extent
        logic [COORD_W-1:0]         adm;     // minor extent
        logic [GLYPH_W-1:0]         glyph;
        logic [COLOR_W-1:0]         fore;
        logic [COLOR_W-1:0]         back;
        logic                       wide;
    } cmd_t;

    // Stepper states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } back_state_t;

endpackage

/* rtl/cdls_front.sv */
`timescale 1ns / 1ps
// Front end of the line stepper: accepts line commands and classifies them
// into major axis, start point, extents and step directions.
// Depends on cdls_pkg.
module cdls_front (
    input  logic signed [cdls_pkg::COORD_W-1:0] s_start_x,
    input  logic signed [cdls_pkg::COORD_W-1:0] s_start_y,
    input  logic signed [cdls_pkg::COORD_W-1:0] s_end_x,
    input  logic signed [cdls_pkg::COORD_W-1:0] s_end_y,
    input  logic                                s_reverse,
    input  logic [cdls_pkg::GLYPH_W-1:0]        s_glyph,
    input  logic [cdls_pkg::COLOR_W-1:0]        s_fore_color,
    input  logic [cdls_pkg::COLOR_W-1:0]        s_back_color,
    input  logic                                s_wide_mark,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                q_full,
    output logic                                q_push,
    output cdls_pkg::cmd_t                      q_cmd
);
    import cdls_pkg::*;

    logic signed [COORD_W:0]   dx;
    logic signed [COORD_W:0]   dy;
    logic [COORD_W-1:0]        adx;
    logic [COORD_W-1:0]        ady;
    logic                      xmaj;
    logic signed [COORD_W-1:0] ma1;
    logic signed [COORD_W-1:0] ma2;
    logic signed [COORD_W-1:0] mi1;
    logic signed [COORD_W-1:0] mi2;
    logic                      from_first;
    logic signed [COORD_W-1:0] emi;

    // A command is taken whenever the queue has room.
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Extents on both axes; the larger one is the major axis, x on a tie.
    always_comb begin
        dx   = {s_start_x[COORD_W-1], s_start_x} - {s_end_x[COORD_W-1], s_end_x};
        dy   = {s_start_y[COORD_W-1], s_start_y} - {s_end_y[COORD_W-1], s_end_y};
        adx  = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
        ady  = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
        xmaj = (adx >= ady);
    end

    // Choose the start endpoint and the step directions.
    always_comb begin
        ma1        = xmaj ? s_start_x : s_start_y;
        mi1        = xmaj ? s_start_y : s_start_x;
        ma2        = xmaj ? s_end_x   : s_end_y;
        mi2        = xmaj ? s_end_y   : s_end_x;
        from_first = (ma1 < ma2) ^ s_reverse;
        emi        = from_first ? mi2 : mi1;

        q_cmd.xmaj   = xmaj;
        q_cmd.ma_dec = s_reverse;
        q_cmd.sma    = from_first ? ma1 : ma2;
        q_cmd.smi    = from_first ? mi1 : mi2;
        q_cmd.mi_neg = (emi < q_cmd.smi);
        q_cmd.amaj   = xmaj ? adx : ady;
        q_cmd.adm    = xmaj ? ady : adx;
        q_cmd.glyph  = s_glyph;
        q_cmd.fore   = s_fore_color;
        q_cmd.back   = s_back_color;
        q_cmd.wide   = s_wide_mark;
    end

endmodule

/* rtl/cdls_queue.sv */
`timescale 1ns / 1ps
// Short command queue between the front end and the stepper, so that each
// side can stall on its own.
// Depends on cdls_pkg.
module cdls_queue #(
    parameter int DEPTH = cdls_pkg::CMD_QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  cdls_pkg::cmd_t push_cmd,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output cdls_pkg::cmd_t head_cmd
);
    import cdls_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* rtl/cdls_back.sv */
`timescale 1ns / 1ps
// Stepper of the line stepper: walks one major-axis position per cycle unless
// the output stalls, clips against the screen, holds one kept cell back to mark the last one.
// Depends on cdls_pkg.
module cdls_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [cdls_pkg::DIM_W-1:0]    scr_w,
    input  logic [cdls_pkg::DIM_W-1:0]    scr_h,
    input  logic                          q_not_empty,
    input  cdls_pkg::cmd_t                q_cmd,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [cdls_pkg::CELL_W-1:0]   m_cell_x,
    output logic [cdls_pkg::CELL_W-1:0]   m_cell_y,
    output logic [cdls_pkg::GLYPH_W-1:0]  m_cell_glyph,
    output logic [cdls_pkg::COLOR_W-1:0]  m_cell_fore,
    output logic [cdls_pkg::COLOR_W-1:0]  m_cell_back,
    output logic                          m_cell_wide,
    output logic                          m_last
);
    import cdls_pkg::*;

    back_state_t               state_reg;
    back_state_t               state_next;
    cmd_t                      cmd_reg;
    logic signed [COORD_W-1:0] ma_reg;
    logic signed [COORD_W-1:0] ma_next;
    logic signed [COORD_W-1:0] mi_reg;
    logic signed [COORD_W-1:0] mi_next;
    logic [ERR_W-1:0]          err_reg;
    logic [ERR_W-1:0]          err_next;
    logic [ERR_W-1:0]          err_sum;
    logic [COORD_W-1:0]        cnt_reg;
    logic [COORD_W-1:0]        cnt_next;
    logic                      pend_valid_reg;
    logic                      pend_valid_next;
    logic [CELL_W-1:0]         pend_x_reg;
    logic [CELL_W-1:0]         pend_y_reg;
    logic                      m_valid_reg;
    logic                      m_valid_next;
    logic signed [COORD_W-1:0] cur_x;
    logic signed [COORD_W-1:0] cur_y;
    logic                      kept;
    logic                      out_free;
    logic                      step;
    logic                      push_mid;
    logic                      push_last;
    logic                      load;

    // Current cell and its screen test.
    always_comb begin
        cur_x    = cmd_reg.xmaj ? ma_reg : mi_reg;
        cur_y    = cmd_reg.xmaj ? mi_reg : ma_reg;
        kept     = !cur_x[COORD_W-1] && (cur_x[COORD_W-2:0] < scr_w)
                && !cur_y[COORD_W-1] && (cur_y[COORD_W-2:0] < scr_h);
        out_free = !m_valid_reg || m_ready;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_not_empty) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (step && (cnt_reg == '0)) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs: load, step and the two kinds of output transfer.
    always_comb begin
        load      = 1'b0;
        step      = 1'b0;
        push_mid  = 1'b0;
        push_last = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                load = q_not_empty;
            end
            ST_RUN: begin
                step     = !(kept && pend_valid_reg && !out_free);
                push_mid = step && kept && pend_valid_reg;
            end
            ST_FLUSH: begin
                push_last = pend_valid_reg && out_free;
            end
            default: begin
                load = 1'b0;
            end
        endcase
    end

    assign q_pop = load;

    // Walk arithmetic: exact integer error term scaled by the major extent.
    always_comb begin
        ma_next  = ma_reg;
        mi_next  = mi_reg;
        err_next = err_reg;
        cnt_next = cnt_reg;
        err_sum  = err_reg + {1'b0, cmd_reg.adm};
        if (load) begin
            ma_next  = q_cmd.sma;
            mi_next  = q_cmd.smi;
            err_next = '0;
            cnt_next = q_cmd.amaj;
        end else if (step) begin
            ma_next  = cmd_reg.ma_dec ? ma_reg - 1'b1 : ma_reg + 1'b1;
            cnt_next = cnt_reg - 1'b1;
            if (err_sum >= {1'b0, cmd_reg.amaj}) begin
                mi_next  = cmd_reg.mi_neg ? mi_reg - 1'b1 : mi_reg + 1'b1;
                err_next = err_sum - {1'b0, cmd_reg.amaj};
            end else begin
                err_next = err_sum;
            end
        end
    end

    // Held-back cell and output register valid.
    always_comb begin
        pend_valid_next = pend_valid_reg;
        if (step && kept) begin
            pend_valid_next = 1'b1;
        end else if (push_last) begin
            pend_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (push_mid || push_last) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (load) begin
            cmd_reg <= q_cmd;
        end
        ma_reg  <= ma_next;
        mi_reg  <= mi_next;
        err_reg <= err_next;
        cnt_reg <= cnt_next;
        if (step && kept) begin
            pend_x_reg <= cur_x[CELL_W-1:0];
            pend_y_reg <= cur_y[CELL_W-1:0];
        end
        if (push_mid || push_last) begin
            m_cell_x     <= pend_x_reg;
            m_cell_y     <= pend_y_reg;
            m_cell_glyph <= cmd_reg.glyph;
            m_cell_fore  <= cmd_reg.fore;
            m_cell_back  <= cmd_reg.back;
            m_cell_wide  <= cmd_reg.wide;
            m_last       <= push_last;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

/* rtl/clipped_dda_line_stepper.sv */
`timescale 1ns / 1ps
// Top level of the clipped DDA line stepper: screen registers, front end,
// command queue and stepper. Depends on cdls_pkg, cdls_front, cdls_queue
// and cdls_back.
//
// A line command becomes the cell writes of a DDA line, clipped to the
// screen set by the width and height registers (index 0 and 1, values above
// MAX_SCREEN_DIM saturate), with last set on the final kept cell. The
// stepper walks one major-axis position per cycle unless a result channel
// stall holds it, so a command whose major extent is N visits N + 1
// positions, after a load step and before a flush step that releases the
// held-back last cell. Up to two further commands wait in the queue in
// front of the stepper, so the input channel keeps taking transfers while a
// line is drawn. Configuration writes are always taken and must only be
// made while no command is in flight.
module clipped_dda_line_stepper #(
    parameter int MAX_SCREEN_DIM = cdls_pkg::MAX_SCREEN_DIM_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cdls_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cdls_pkg::DIM_W-1:0]          cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [cdls_pkg::COORD_W-1:0] s_start_x,
    input  logic signed [cdls_pkg::COORD_W-1:0] s_start_y,
    input  logic signed [cdls_pkg::COORD_W-1:0] s_end_x,
    input  logic signed [cdls_pkg::COORD_W-1:0] s_end_y,
    input  logic                                s_reverse,
    input  logic [cdls_pkg::GLYPH_W-1:0]        s_glyph,
    input  logic [cdls_pkg::COLOR_W-1:0]        s_fore_color,
    input  logic [cdls_pkg::COLOR_W-1:0]        s_back_color,
    input  logic                                s_wide_mark,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [cdls_pkg::CELL_W-1:0]         m_cell_x,
    output logic [cdls_pkg::CELL_W-1:0]         m_cell_y,
    output logic [cdls_pkg::GLYPH_W-1:0]        m_cell_glyph,
    output logic [cdls_pkg::COLOR_W-1:0]        m_cell_fore,
    output logic [cdls_pkg::COLOR_W-1:0]        m_cell_back,
    output logic                                m_cell_wide,
    output logic                                m_last
);
    import cdls_pkg::*;

    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_SCREEN_DIM);

    logic [DIM_W-1:0] scr_w_reg;
    logic [DIM_W-1:0] scr_w_next;
    logic [DIM_W-1:0] scr_h_reg;
    logic [DIM_W-1:0] scr_h_next;
    logic [DIM_W-1:0] scr_w_eff;
    logic [DIM_W-1:0] scr_h_eff;
    logic             q_full;
    logic             q_push;
    logic             q_pop;
    logic             q_not_empty;
    cmd_t             front_cmd;
    cmd_t             head_cmd;

    assign cfg_ready = 1'b1;

    // Screen register writes; unknown indexes are ignored.
    always_comb begin
        scr_w_next = scr_w_reg;
        scr_h_next = scr_h_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  scr_w_next = cfg_data;
                REG_SCREEN_HEIGHT: scr_h_next = cfg_data;
                default: begin
                    scr_w_next = scr_w_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scr_w_reg <= SCREEN_RESET;
            scr_h_reg <= SCREEN_RESET;
        end else begin
            scr_w_reg <= scr_w_next;
            scr_h_reg <= scr_h_next;
        end
    end

    // Saturate the screen size to the largest supported dimension.
    assign scr_w_eff = (scr_w_reg > DIM_MAX) ? DIM_MAX : scr_w_reg;
    assign scr_h_eff = (scr_h_reg > DIM_MAX) ? DIM_MAX : scr_h_reg;

    cdls_front u_front (
        .s_start_x    (s_start_x),
        .s_start_y    (s_start_y),
        .s_end_x      (s_end_x),
        .s_end_y      (s_end_y),
        .s_reverse    (s_reverse),
        .s_glyph      (s_glyph),
        .s_fore_color (s_fore_color),
        .s_back_color (s_back_color),
        .s_wide_mark  (s_wide_mark),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (front_cmd)
    );

    cdls_queue #(
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (front_cmd),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    cdls_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .scr_w        (scr_w_eff),
        .scr_h        (scr_h_eff),
        .q_not_empty  (q_not_empty),
        .q_cmd        (head_cmd),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cell_x     (m_cell_x),
        .m_cell_y     (m_cell_y),
        .m_cell_glyph (m_cell_glyph),
        .m_cell_fore  (m_cell_fore),
        .m_cell_back  (m_cell_back),
        .m_cell_wide  (m_cell_wide),
        .m_last       (m_last)
    );

endmodule

/* rtl/cdls_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the clipped DDA line stepper, bound to the top level.
// Depends on cdls_pkg and clipped_dda_line_stepper.
module cdls_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               cfg_valid,
    input logic                               cfg_ready,
    input logic [cdls_pkg::CFG_IDX_W-1:0]     cfg_index,
    input logic [cdls_pkg::DIM_W-1:0]         cfg_data,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [cdls_pkg::CELL_W-1:0]        m_cell_x,
    input logic [cdls_pkg::CELL_W-1:0]        m_cell_y,
    input logic [cdls_pkg::GLYPH_W-1:0]       m_cell_glyph,
    input logic [cdls_pkg::COLOR_W-1:0]       m_cell_fore,
    input logic [cdls_pkg::COLOR_W-1:0]       m_cell_back,
    input logic                               m_cell_wide,
    input logic                               m_last
);
    import cdls_pkg::*;

    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_SCREEN_DIM_DEF);

    logic [DIM_W-1:0] shadow_w_reg;
    logic [DIM_W-1:0] shadow_h_reg;
    logic [DIM_W-1:0] lim_w;
    logic [DIM_W-1:0] lim_h;

    // Shadow copies of the screen registers, taken from the write transfers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shadow_w_reg <= SCREEN_RESET;
            shadow_h_reg <= SCREEN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_SCREEN_WIDTH) begin
                shadow_w_reg <= cfg_data;
            end
            if (cfg_index == REG_SCREEN_HEIGHT) begin
                shadow_h_reg <= cfg_data;
            end
        end
    end

    assign lim_w = (shadow_w_reg > DIM_MAX) ? DIM_MAX : shadow_w_reg;
    assign lim_h = (shadow_h_reg > DIM_MAX) ? DIM_MAX : shadow_h_reg;

    // No result is offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered straight after reset");

    // A stalled result holds its payload.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable({m_cell_x, m_cell_y, m_cell_glyph,
            m_cell_fore, m_cell_back, m_cell_wide, m_last}))
        else $error("stalled result changed");

    // Every delivered cell lies inside the configured screen.
    a_col_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_cell_x} < lim_w))
        else $error("cell column outside the screen");

    a_row_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_cell_y} < lim_h))
        else $error("cell row outside the screen");

endmodule

bind clipped_dda_line_stepper cdls_checker u_cdls_checker (.*);

/* tb/sv/tb_cell_pkg.sv */
`timescale 1ns / 1ps
// Scoreboard package of the line stepper testbench: line command and cell types,
// and a class that predicts the clipped DDA cells of each accepted line and
// checks the result transfers against them. Depends on cdls_pkg.
package tb_cell_pkg;
    import cdls_pkg::*;

    // A line never yields more cells than the widest screen has columns or rows.
    localparam int MAX_LINE_CELLS = 64;

    typedef struct packed {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
        logic                      reverse;
        logic [GLYPH_W-1:0]        glyph;
        logic [COLOR_W-1:0]        fore;
        logic [COLOR_W-1:0]        back;
        logic                      wide;
    } line_cmd_t;

    typedef struct packed {
        logic [CELL_W-1:0]  x;
        logic [CELL_W-1:0]  y;
        logic [GLYPH_W-1:0] glyph;
        logic [COLOR_W-1:0] fore;
        logic [COLOR_W-1:0] back;
        logic               wide;
        logic               last;
    } cell_t;

    class cell_scoreboard;
        cell_t            expected_cells[$];
        logic [DIM_W-1:0] width_reg;
        logic [DIM_W-1:0] height_reg;
        int               errors;
        line_cmd_t        cur_line;
        int               kept;

        function new();
            width_reg  = SCREEN_RESET;
            height_reg = SCREEN_RESET;
            errors     = 0;
        endfunction

        // Register writes with a spare index leave the screen untouched.
        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
            case (idx)
                REG_SCREEN_WIDTH: begin
                    width_reg = data;
                end
                REG_SCREEN_HEIGHT: begin
                    height_reg = data;
                end
                default: begin
                end
            endcase
        endfunction

        function int screen_dim(logic [DIM_W-1:0] v);
            return (v > MAX_SCREEN_DIM_DEF) ? MAX_SCREEN_DIM_DEF : int'(v);
        endfunction

        // Queue one cell of the current line unless it falls off the screen or the line is full.
        function void keep_cell(int cx, int cy);
            cell_t c;
            if (cx < 0 || cx >= screen_dim(width_reg) || cy < 0 ||
                    cy >= screen_dim(height_reg) || kept >= MAX_LINE_CELLS) begin
                return;
            end
            c.x     = cx[CELL_W-1:0];
            c.y     = cy[CELL_W-1:0];
            c.glyph = cur_line.glyph;
            c.fore  = cur_line.fore;
            c.back  = cur_line.back;
            c.wide  = cur_line.wide;
            c.last  = 1'b0;
            expected_cells.push_back(c);
            kept++;
        endfunction

        // Step the major axis one position at a time with an exact error term
        // scaled by the major extent.
        function void trace_major(int ma1, int mi1, int ma2, int mi2, bit rev, bit xmaj);
            bit from_first;
            int sma;
            int smi;
            int ema;
            int emi;
            int dmaj;
            int dmin;
            int amaj;
            int dir;
            int inc;
            int err;
            int mi;
            int ma;
            from_first = (ma1 < ma2) != rev;
            sma  = from_first ? ma1 : ma2;
            smi  = from_first ? mi1 : mi2;
            ema  = from_first ? ma2 : ma1;
            emi  = from_first ? mi2 : mi1;
            dmaj = ema - sma;
            dmin = emi - smi;
            amaj = (dmaj < 0) ? -dmaj : dmaj;
            dir  = rev ? -1 : 1;
            inc  = (dmaj > 0) ? dmin : -dmin;
            err  = 0;
            mi   = smi;
            for (int i = 0; i <= amaj; i++) begin
                ma = sma + dir * i;
                if (xmaj) begin
                    keep_cell(ma, mi);
                end else begin
                    keep_cell(mi, ma);
                end
                err += inc;
                if (err >= amaj) begin
                    mi  += dir;
                    err -= amaj;
                end else if (err <= -amaj) begin
                    mi  -= dir;
                    err += amaj;
                end
            end
        endfunction

        // An accepted line command: append every cell it should produce.
        function void note_line(line_cmd_t c);
            int    x1;
            int    y1;
            int    x2;
            int    y2;
            int    adx;
            int    ady;
            int    first;
            cell_t tail;
            x1 = int'(c.sx);
            y1 = int'(c.sy);
            x2 = int'(c.ex);
            y2 = int'(c.ey);
            adx = (x1 > x2) ? x1 - x2 : x2 - x1;
            ady = (y1 > y2) ? y1 - y2 : y2 - y1;
            cur_line = c;
            kept     = 0;
            first    = expected_cells.size();
            if (adx == 0 && ady == 0) begin
                keep_cell(x1, y1);
            end else if (adx >= ady) begin
                trace_major(x1, y1, x2, y2, c.reverse, 1'b1);
            end else begin
                trace_major(y1, x1, y2, x2, c.reverse, 1'b0);
            end
            // The final kept cell of the line carries last.
            if (expected_cells.size() > first) begin
                tail      = expected_cells.pop_back();
                tail.last = 1'b1;
                expected_cells.push_back(tail);
            end
        endfunction

        // One result transfer against the oldest expected cell.
        function void check_cell(cell_t got);
            cell_t want;
            if (expected_cells.size() == 0) begin
                $display("%0t: cell (%0d,%0d) arrived with nothing expected",
                         $time, got.x, got.y);
                errors++;
                return;
            end
            want = expected_cells.pop_front();
            if (got.x !== want.x) begin
                $display("%0t: cell_x expected %0d, got %0d", $time, want.x, got.x);
                errors++;
            end
            if (got.y !== want.y) begin
                $display("%0t: cell_y expected %0d, got %0d", $time, want.y, got.y);
                errors++;
            end
            if (got.glyph !== want.glyph) begin
                $display("%0t: cell_glyph expected %h, got %h", $time, want.glyph, got.glyph);
                errors++;
            end
            if (got.fore !== want.fore) begin
                $display("%0t: cell_fore expected %h, got %h", $time, want.fore, got.fore);
                errors++;
            end
            if (got.back !== want.back) begin
                $display("%0t: cell_back expected %h, got %h", $time, want.back, got.back);
                errors++;
            end
            if (got.wide !== want.wide) begin
                $display("%0t: cell_wide expected %b, got %b", $time, want.wide, got.wide);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %b, got %b", $time, want.last, got.last);
                errors++;
            end
        endfunction

        function int pending_count();
            return expected_cells.size();
        endfunction
    endclass

endpackage

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Top of the line stepper testbench: drives line commands and screen register
// writes into clipped_dda_line_stepper and checks every cell transfer.
// Depends on cdls_pkg, tb_cell_pkg and the stepper RTL.
module tb_top;
    import cdls_pkg::*;
    import tb_cell_pkg::*;

    // Register indexes the block does not decode; writes to them are dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // Up to three commands, two queued and one in the stepper, may still be
    // working on cells that are all off screen.
    localparam int DRAIN_CYCLES = 800;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] idx;
        logic [DIM_W-1:0]     data;
    } reg_write_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [DIM_W-1:0]          cfg_data;
    logic                      s_valid;
    logic                      s_ready;
    logic signed [COORD_W-1:0] s_start_x;
    logic signed [COORD_W-1:0] s_start_y;
    logic signed [COORD_W-1:0] s_end_x;
    logic signed [COORD_W-1:0] s_end_y;
    logic                      s_reverse;
    logic [GLYPH_W-1:0]        s_glyph;
    logic [COLOR_W-1:0]        s_fore_color;
    logic [COLOR_W-1:0]        s_back_color;
    logic                      s_wide_mark;
    logic                      m_valid;
    logic                      m_ready;
    logic [CELL_W-1:0]         m_cell_x;
    logic [CELL_W-1:0]         m_cell_y;
    logic [GLYPH_W-1:0]        m_cell_glyph;
    logic [COLOR_W-1:0]        m_cell_fore;
    logic [COLOR_W-1:0]        m_cell_back;
    logic                      m_cell_wide;
    logic                      m_last;

    cell_scoreboard sb;
    bit             calm;

    clipped_dda_line_stepper i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_start_x    (s_start_x),
        .s_start_y    (s_start_y),
        .s_end_x      (s_end_x),
        .s_end_y      (s_end_y),
        .s_reverse    (s_reverse),
        .s_glyph      (s_glyph),
        .s_fore_color (s_fore_color),
        .s_back_color (s_back_color),
        .s_wide_mark  (s_wide_mark),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cell_x     (m_cell_x),
        .m_cell_y     (m_cell_y),
        .m_cell_glyph (m_cell_glyph),
        .m_cell_fore  (m_cell_fore),
        .m_cell_back  (m_cell_back),
        .m_cell_wide  (m_cell_wide),
        .m_last       (m_last)
    );

    // 10 ns clock.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Build a command; payload_kind 0 gives an all-zero payload, 1 all ones,
    // anything else a random one.
    function automatic line_cmd_t make_line(int sx, int sy, int ex, int ey, bit rev,
                                            int payload_kind);
        line_cmd_t l;
        l.sx      = sx[COORD_W-1:0];
        l.sy      = sy[COORD_W-1:0];
        l.ex      = ex[COORD_W-1:0];
        l.ey      = ey[COORD_W-1:0];
        l.reverse = rev;
        if (payload_kind == 0) begin
            l.glyph = '0;
            l.fore  = '0;
            l.back  = '0;
            l.wide  = 1'b0;
        end else if (payload_kind == 1) begin
            l.glyph = '1;
            l.fore  = '1;
            l.back  = '1;
            l.wide  = 1'b1;
        end else begin
            l.glyph = GLYPH_W'($urandom_range(0, 65535));
            l.fore  = COLOR_W'($urandom_range(0, 16777215));
            l.back  = COLOR_W'($urandom_range(0, 16777215));
            l.wide  = 1'($urandom_range(0, 1));
        end
        return l;
    endfunction

    // Most random lines stay near the screen so that cells come out, some as single
    // points or straight runs; the rest use the whole coordinate range.
    function automatic line_cmd_t random_line();
        int kind;
        int sx;
        int sy;
        int len;
        bit rev;
        kind = $urandom_range(0, 9);
        sx   = $urandom_range(0, 79) - 8;
        sy   = $urandom_range(0, 79) - 8;
        len  = $urandom_range(0, 70) - 35;
        rev  = 1'($urandom_range(0, 1));
        case (kind)
            0: return make_line($urandom_range(0, 255) - 128, $urandom_range(0, 255) - 128,
                                $urandom_range(0, 255) - 128, $urandom_range(0, 255) - 128,
                                rev, 2);
            1: return make_line(sx, sy, sx, sy, rev, 2);
            2: return make_line(sx, sy, sx + len, sy, rev, 2);
            3: return make_line(sx, sy, sx, sy + len, rev, 2);
            4: return make_line(sx, sy, sx + len, sy - len, rev, 2);
            default: return make_line(sx, sy, $urandom_range(0, 79) - 8,
                                      $urandom_range(0, 79) - 8, rev, 2);
        endcase
    endfunction

    // One command transfer, after an optional idle burst. Valid stays high
    // after the transfer; the caller lowers it at the end of a phase.
    task automatic send_line(input line_cmd_t l);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_start_x    <= l.sx;
        s_start_y    <= l.sy;
        s_end_x      <= l.ex;
        s_end_y      <= l.ey;
        s_reverse    <= l.reverse;
        s_glyph      <= l.glyph;
        s_fore_color <= l.fore;
        s_back_color <= l.back;
        s_wide_mark  <= l.wide;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_line(l);
    endtask

    task automatic send_random_lines(input int count);
        for (int n = 0; n < count; n++) begin
            send_line(random_line());
        end
        s_valid <= 1'b0;
    endtask

    // Wait until every expected cell is out and any off-screen work is done.
    task automatic settle();
        while (sb.pending_count() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Program both screen registers, and optionally the two spare indexes.
    task automatic write_screen(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                input bit with_spare);
        reg_write_t plan[4];
        int         count;
        plan[0].idx  = REG_SCREEN_WIDTH;
        plan[0].data = w;
        plan[1].idx  = REG_SCREEN_HEIGHT;
        plan[1].data = h;
        plan[2].idx  = REG_SPARE_A;
        plan[2].data = DIM_W'($urandom_range(0, 127));
        plan[3].idx  = REG_SPARE_B;
        plan[3].data = DIM_W'($urandom_range(0, 127));
        count = with_spare ? 4 : 2;
        for (int n = 0; n < count; n++) begin
            cfg_valid <= 1'b1;
            cfg_index <= plan[n].idx;
            cfg_data  <= plan[n].data;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            sb.set_reg(plan[n].idx, plan[n].data);
        end
        cfg_valid <= 1'b0;
    endtask

    // Result side: check each transfer and stall in random bursts, with
    // regular stretches of steady readiness.
    initial begin
        int    stall;
        int    cycle;
        cell_t got;
        stall = 0;
        cycle = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            cycle++;
            if (aresetn && m_valid && m_ready) begin
                got.x     = m_cell_x;
                got.y     = m_cell_y;
                got.glyph = m_cell_glyph;
                got.fore  = m_cell_fore;
                got.back  = m_cell_back;
                got.wide  = m_cell_wide;
                got.last  = m_last;
                sb.check_cell(got);
            end
            if (calm || (cycle % 160) < 50) begin
                stall = 0;
            end else if (stall == 0 && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 6);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Stimulus.
    initial begin
        sb   = new();
        calm = 1'b0;
        aresetn      <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= REG_SCREEN_WIDTH;
        cfg_data     <= '0;
        s_valid      <= 1'b0;
        s_start_x    <= '0;
        s_start_y    <= '0;
        s_end_x      <= '0;
        s_end_y      <= '0;
        s_reverse    <= 1'b0;
        s_glyph      <= '0;
        s_fore_color <= '0;
        s_back_color <= '0;
        s_wide_mark  <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed lines on the reset screen of 64 by 64.
        send_line(make_line(0, 0, 0, 0, 1'b0, 0));          // single point at the origin
        send_line(make_line(63, 63, 63, 63, 1'b1, 1));      // single point in the far corner
        send_line(make_line(-1, 5, -1, 5, 1'b0, 2));        // single point off screen
        send_line(make_line(0, 0, 63, 0, 1'b0, 1));         // top row, forward
        send_line(make_line(0, 0, 63, 0, 1'b1, 0));         // top row, reversed
        send_line(make_line(63, 63, 63, 0, 1'b0, 2));       // right column
        send_line(make_line(0, 0, 63, 63, 1'b0, 2));        // main diagonal
        send_line(make_line(63, 0, 0, 63, 1'b1, 2));        // anti-diagonal, reversed
        send_line(make_line(5, 60, 10, 2, 1'b1, 2));        // steep, reversed
        send_line(make_line(60, 3, 2, 10, 1'b0, 2));        // shallow, falling
        send_line(make_line(-128, -128, 127, 127, 1'b0, 1));
        send_line(make_line(127, -128, -128, 127, 1'b1, 0));
        send_line(make_line(-128, 127, 127, -128, 1'b0, 2));
        send_line(make_line(-128, -100, -20, -5, 1'b0, 2)); // whole line off screen
        send_line(make_line(10, 20, 20, 10, 1'b1, 2));      // equal extents, x is major
        send_line(make_line(-5, 30, 70, 33, 1'b0, 2));      // clipped at both ends
        send_line(make_line(30, -7, 33, 90, 1'b1, 2));      // clipped vertically
        send_line(make_line(127, 127, 127, 127, 1'b0, 2));  // single point far off screen
        s_valid <= 1'b0;

        // Random lines on the full screen.
        send_random_lines(15);
        settle();

        // Zero width, then zero height: nothing is kept.
        write_screen(7'd0, 7'd64, 1'b0);
        send_random_lines(6);
        settle();
        write_screen(7'd64, 7'd0, 1'b0);
        send_random_lines(4);
        settle();

        // Oversized width saturates; a single row; spare indexes are ignored.
        write_screen(7'd127, 7'd1, 1'b1);
        send_line(make_line(-10, 0, 100, 0, 1'b0, 2));
        send_random_lines(12);
        settle();

        // A single column with an oversized height.
        write_screen(7'd1, 7'd127, 1'b1);
        send_line(make_line(0, -20, 0, 100, 1'b1, 2));
        send_random_lines(8);
        settle();

        // A few random screens.
        for (int p = 0; p < 5; p++) begin
            write_screen(DIM_W'($urandom_range(1, 64)), DIM_W'($urandom_range(1, 64)),
                         1'($urandom_range(0, 1)));
            send_random_lines(5);
            settle();
        end

        // Closing stretch with no idling on either side.
        write_screen(7'd64, 7'd64, 1'b0);
        calm = 1'b1;
        send_random_lines(20);

        settle();
        if (sb.errors == 0 && sb.pending_count() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
